[hdl/alc_pkg.sv]
package alc_pkg;

    localparam int VIS_W  = 16;
    localparam int TIME_W = 10;
    localparam int GAIN_W = 14;
    localparam int VT_W   = VIS_W + TIME_W;
    localparam int DEN_W  = VT_W + GAIN_W;
    localparam int LUX_W  = 48;

    // operand prep, squares, products, range check
    localparam int FRONT_STAGES = 4;
    localparam int LATENCY      = FRONT_STAGES + LUX_W + 1;

    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_TIME = 1'b0;
    localparam logic [0:0] REG_GAIN = 1'b1;

    typedef struct packed {
        logic [VIS_W-1:0] visible_count;
        logic [VIS_W-1:0] ir_count;
    } reading_t;

    typedef struct packed {
        logic [LUX_W-1:0] lux_fixed;
        logic             no_light;
        logic             saturated;
    } result_t;

    // Token carried down the divider row. work holds the unused dividend
    // bits at the top and the quotient bits shifted in at the bottom.
    typedef struct packed {
        logic             no_light;
        logic             sat;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [LUX_W-1:0] work;
    } div_tok_t;

    function automatic logic [TIME_W-1:0] time_ms(input logic [2:0] code);
        logic [TIME_W-1:0] t;
        unique case (code)
            3'd0:    t = TIME_W'(100);
            3'd1:    t = TIME_W'(200);
            3'd2:    t = TIME_W'(300);
            3'd3:    t = TIME_W'(400);
            3'd4:    t = TIME_W'(500);
            3'd5:    t = TIME_W'(600);
            default: t = TIME_W'(100);
        endcase
        return t;
    endfunction

    function automatic logic [GAIN_W-1:0] gain_val(input logic [1:0] code);
        logic [GAIN_W-1:0] g;
        unique case (code)
            2'd0:    g = GAIN_W'(1);
            2'd1:    g = GAIN_W'(25);
            2'd2:    g = GAIN_W'(428);
            default: g = GAIN_W'(9876);
        endcase
        return g;
    endfunction

endpackage

[hdl/alc_front.sv]
module alc_front #(
    parameter int LUX_DIVISOR_FACTOR = 408,
    parameter int FRACTION_BITS      = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  alc_pkg::reading_t             reading,
    input  logic [alc_pkg::TIME_W-1:0]    time_val,
    input  logic [alc_pkg::GAIN_W-1:0]    gain_val,
    output logic                          tok_valid,
    output alc_pkg::div_tok_t             tok
);

    localparam int DF_W  = $clog2(LUX_DIVISOR_FACTOR + 1);
    localparam int SQ_W  = 2 * alc_pkg::VIS_W;
    localparam int NUM_W = SQ_W + DF_W;
    localparam int X_W   = NUM_W + FRACTION_BITS + alc_pkg::LUX_W;

    // stage 1: difference magnitude
    logic [2:0]                     vld_reg, vld_next;
    logic [alc_pkg::VIS_W-1:0]      vis1_reg, vis1_next;
    logic [alc_pkg::VIS_W-1:0]      diff1_reg, diff1_next;
    logic [alc_pkg::TIME_W-1:0]     time1_reg;
    logic [alc_pkg::GAIN_W-1:0]     gain1_reg, gain2_reg;
    logic                           nl1_reg, nl2_reg, nl3_reg;
    // stage 2: square and vis*time
    logic [SQ_W-1:0]                sq2_reg, sq2_next;
    logic [alc_pkg::VT_W-1:0]       vt2_reg, vt2_next;
    // stage 3: numerator and denominator
    logic [NUM_W-1:0]               num3_reg, num3_next;
    logic [alc_pkg::DEN_W-1:0]      den3_reg, den3_next;
    // stage 4: range check and divider seed
    logic                           tok_valid_reg;
    alc_pkg::div_tok_t              tok_reg, tok_next;
    logic [X_W-1:0]                 n_ext, hi_ext;

    always_comb
    begin
        vis1_next  = reading.visible_count;
        diff1_next = (reading.visible_count >= reading.ir_count)
                   ? reading.visible_count - reading.ir_count
                   : reading.ir_count - reading.visible_count;
        vld_next   = {vld_reg[1:0], start};

        sq2_next  = SQ_W'(diff1_reg) * SQ_W'(diff1_reg);
        vt2_next  = alc_pkg::VT_W'(vis1_reg) * alc_pkg::VT_W'(time1_reg);

        num3_next = NUM_W'(sq2_reg) * NUM_W'(LUX_DIVISOR_FACTOR);
        den3_next = alc_pkg::DEN_W'(vt2_reg) * alc_pkg::DEN_W'(gain2_reg);

        // quotient fits the field only if the top part of num<<F is below den
        n_ext  = X_W'(num3_reg) << FRACTION_BITS;
        hi_ext = n_ext >> alc_pkg::LUX_W;
        tok_next.no_light = nl3_reg;
        tok_next.sat      = (hi_ext >= X_W'(den3_reg));
        tok_next.den      = den3_reg;
        tok_next.rem      = hi_ext[alc_pkg::DEN_W-1:0];
        tok_next.work     = n_ext[alc_pkg::LUX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            tok_valid_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        vis1_reg  <= vis1_next;
        diff1_reg <= diff1_next;
        time1_reg <= time_val;
        gain1_reg <= gain_val;
        nl1_reg   <= (reading.visible_count == '0);

        sq2_reg   <= sq2_next;
        vt2_reg   <= vt2_next;
        gain2_reg <= gain1_reg;
        nl2_reg   <= nl1_reg;

        num3_reg  <= num3_next;
        den3_reg  <= den3_next;
        nl3_reg   <= nl2_reg;

        tok_reg   <= tok_next;
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

[hdl/alc_div_cell.sv]
module alc_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  alc_pkg::div_tok_t tok_in,
    output logic              valid_out,
    output alc_pkg::div_tok_t tok_out
);

    logic                           valid_reg;
    alc_pkg::div_tok_t              tok_reg, tok_next;
    logic [alc_pkg::DEN_W:0]        trial, trial_sub;
    logic                           take;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        trial     = {tok_in.rem, tok_in.work[alc_pkg::LUX_W-1]};
        trial_sub = trial - {1'b0, tok_in.den};
        take      = (trial >= {1'b0, tok_in.den});
        tok_next      = tok_in;
        tok_next.rem  = take ? trial_sub[alc_pkg::DEN_W-1:0] : trial[alc_pkg::DEN_W-1:0];
        tok_next.work = {tok_in.work[alc_pkg::LUX_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign valid_out = valid_reg;
    assign tok_out   = tok_reg;

endmodule

[hdl/ambient_light_lux_calc_unit.sv]
// Lux conversion from a full-spectrum and an infrared count:
// lux = (visible - ir)^2 * LUX_DIVISOR_FACTOR / (visible * time_ms * gain), as unsigned
// fixed point with FRACTION_BITS fraction bits, truncated, clamped to 48 bits with the
// saturated flag; a zero visible count returns zero with no_light set. The unit takes a
// reading on every cycle that start is high (busy stays low) and returns each result in
// order as a one-cycle done strobe. The path runs through four operand and multiplier
// stages, a row of 48 divider cells that each settle one quotient bit per cycle, and the
// output register. Results cannot be held off, so the receiver must take done when it
// shows. Program integration time (0x0) and gain (0x4) over the register port while no
// reading is in flight.
module ambient_light_lux_calc_unit #(
    parameter int LUX_DIVISOR_FACTOR = 408,
    parameter int FRACTION_BITS      = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  alc_pkg::reading_t             reading,
    output logic                          done,
    output alc_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [alc_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int LUX_W = alc_pkg::LUX_W;

    logic [2:0]                 time_code_reg, time_code_next;
    logic [1:0]                 gain_code_reg, gain_code_next;
    logic                       cfg_wr;

    logic                       valid_chain [0:LUX_W];
    alc_pkg::div_tok_t          tok_chain   [0:LUX_W];

    logic                       done_reg, done_next;
    alc_pkg::result_t           result_reg, result_next;
    alc_pkg::div_tok_t          last;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_comb
    begin
        time_code_next = time_code_reg;
        gain_code_next = gain_code_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                alc_pkg::REG_TIME: time_code_next = pwdata[2:0];
                alc_pkg::REG_GAIN: gain_code_next = pwdata[1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            alc_pkg::REG_TIME: prdata = {29'd0, time_code_reg};
            alc_pkg::REG_GAIN: prdata = {30'd0, gain_code_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_code_reg <= '0;
            gain_code_reg <= '0;
        end
        else
        begin
            time_code_reg <= time_code_next;
            gain_code_reg <= gain_code_next;
        end
    end

    alc_front #(
        .LUX_DIVISOR_FACTOR (LUX_DIVISOR_FACTOR),
        .FRACTION_BITS      (FRACTION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .reading   (reading),
        .time_val  (alc_pkg::time_ms(time_code_reg)),
        .gain_val  (alc_pkg::gain_val(gain_code_reg)),
        .tok_valid (valid_chain[0]),
        .tok       (tok_chain[0])
    );

    for (genvar i = 0; i < LUX_W; i++)
    begin : g_cell
        alc_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[i]),
            .tok_in    (tok_chain[i]),
            .valid_out (valid_chain[i+1]),
            .tok_out   (tok_chain[i+1])
        );
    end

    // no_light wins over the range check, which trips on a zero denominator
    always_comb
    begin
        last      = tok_chain[LUX_W];
        done_next = valid_chain[LUX_W];
        result_next.no_light  = last.no_light;
        result_next.saturated = last.sat && !last.no_light;
        priority if (last.no_light)
        begin
            result_next.lux_fixed = '0;
        end
        else if (last.sat)
        begin
            result_next.lux_fixed = '1;
        end
        else
        begin
            result_next.lux_fixed = last.work;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hdl/alc_checker.sv]
module alc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input alc_pkg::reading_t reading,
    input logic              done,
    input alc_pkg::result_t  result
);

    // each beat out matches a start that the unit took earlier
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, alc_pkg::LATENCY))
        else $error("done without a matching start");

    a_dark_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(reading.visible_count, alc_pkg::LATENCY) == '0 |-> result.no_light)
        else $error("zero visible count not flagged");

    a_dark_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.no_light |-> result.lux_fixed == '0 && !result.saturated)
        else $error("no_light result not zero");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.saturated |-> &result.lux_fixed)
        else $error("saturated result not clamped");

endmodule

bind ambient_light_lux_calc_unit alc_checker u_alc_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .reading (reading),
    .done    (done),
    .result  (result)
);

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int LUX_DF      = 408;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_PHASES  = 10;
    localparam int PHASE_ITEMS = 100;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [alc_pkg::ADDR_W-1:0] TIME_ADDR = {alc_pkg::REG_TIME, 2'b00};
    localparam logic [alc_pkg::ADDR_W-1:0] GAIN_ADDR = {alc_pkg::REG_GAIN, 2'b00};

    localparam logic [63:0] LUX_MAX = (64'd1 << alc_pkg::LUX_W) - 64'd1;

    class lux_checker;
        logic [2:0]       time_code;
        logic [1:0]       gain_code;
        alc_pkg::result_t expected_lux[$];
        int               errors;

        function new();
            time_code = '0;
            gain_code = '0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_lux.size();
        endfunction

        function alc_pkg::result_t predict_lux(alc_pkg::reading_t rd);
            alc_pkg::result_t res;
            logic [63:0]      vis;
            logic [63:0]      ir;
            logic [63:0]      diff;
            logic [63:0]      num;
            logic [63:0]      den;
            logic [63:0]      quo;
            logic [63:0]      rem;
            logic [63:0]      lux;
            logic [63:0]      ms;
            logic [63:0]      gain;
            res  = '0;
            vis  = 64'(rd.visible_count);
            ir   = 64'(rd.ir_count);
            if (vis == 64'd0)
            begin
                res.no_light = 1'b1;
                return res;
            end
            // codes 6 and 7 fall back to the shortest integration time
            ms = (time_code <= 3'd5) ? 64'd100 * (64'(time_code) + 64'd1) : 64'd100;
            case (gain_code)
                2'd0:    gain = 64'd1;
                2'd1:    gain = 64'd25;
                2'd2:    gain = 64'd428;
                default: gain = 64'd9876;
            endcase
            diff = (vis >= ir) ? vis - ir : ir - vis;
            num  = diff * diff * 64'(LUX_DF);
            den  = vis * ms * gain;
            quo  = num / den;
            rem  = num % den;
            if (quo > (LUX_MAX >> FRAC_BITS))
            begin
                lux           = LUX_MAX;
                res.saturated = 1'b1;
            end
            else
            begin
                lux = (quo << FRAC_BITS) + ((rem << FRAC_BITS) / den);
                if (lux > LUX_MAX)
                begin
                    lux           = LUX_MAX;
                    res.saturated = 1'b1;
                end
            end
            res.lux_fixed = lux[alc_pkg::LUX_W-1:0];
            return res;
        endfunction

        function void note_reading(alc_pkg::reading_t rd);
            expected_lux.push_back(predict_lux(rd));
        endfunction

        function void check_result(alc_pkg::result_t got);
            alc_pkg::result_t exp_res;
            if (expected_lux.size() == 0)
            begin
                $error("result: none expected, got lux_fixed %h", got.lux_fixed);
                errors++;
                return;
            end
            exp_res = expected_lux.pop_front();
            if (got.lux_fixed !== exp_res.lux_fixed)
            begin
                $error("lux_fixed: expected %h, got %h", exp_res.lux_fixed, got.lux_fixed);
                errors++;
            end
            if (got.no_light !== exp_res.no_light)
            begin
                $error("no_light: expected %b, got %b", exp_res.no_light, got.no_light);
                errors++;
            end
            if (got.saturated !== exp_res.saturated)
            begin
                $error("saturated: expected %b, got %b", exp_res.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic                       clk     = 1'b0;
    logic                       rst_n   = 1'b0;
    logic                       start   = 1'b0;
    logic                       busy;
    alc_pkg::reading_t          reading = '0;
    logic                       done;
    alc_pkg::result_t           result;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [alc_pkg::ADDR_W-1:0] paddr   = '0;
    logic [31:0]                pwdata  = '0;
    logic [31:0]                prdata;
    logic                       pready;

    int unsigned cycles = 0;
    lux_checker  lux_sb = new();

    ambient_light_lux_calc_unit #(
        .LUX_DIVISOR_FACTOR(LUX_DF),
        .FRACTION_BITS     (FRAC_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .reading(reading),
        .done   (done),
        .result (result),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // every done beat is a result; it cannot be held off
    always @(posedge clk)
    begin
        if (rst_n && done)
            lux_sb.check_result(result);
    end

    // one APB transfer, setup then access, with the bus left idle afterwards
    task automatic apb_xfer(input logic wr, input logic [alc_pkg::ADDR_W-1:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [alc_pkg::ADDR_W-1:0] addr,
                             input logic [31:0] exp_val);
        logic [31:0] rdata;
        apb_xfer(1'b0, addr, 32'($urandom), rdata);
        if (rdata !== exp_val)
        begin
            $error("prdata @%0h: expected %h, got %h", addr, exp_val, rdata);
            lux_sb.errors++;
        end
    endtask

    task automatic set_config(input logic [2:0] tcode, input logic [1:0] gcode);
        logic [31:0] rdata;
        // upper data bits are don't-care for the register
        apb_xfer(1'b1, TIME_ADDR, {29'($urandom), tcode}, rdata);
        lux_sb.time_code = tcode;
        apb_xfer(1'b1, GAIN_ADDR, {30'($urandom), gcode}, rdata);
        lux_sb.gain_code = gcode;
        check_reg(TIME_ADDR, 32'(tcode));
        check_reg(GAIN_ADDR, 32'(gcode));
    endtask

    task automatic send_reading(input alc_pkg::reading_t rd, input int gap);
        if (gap > 0)
        begin
            start   <= 1'b0;
            reading <= alc_pkg::reading_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        reading <= rd;
        do
            @(posedge clk);
        while (busy);
        lux_sb.note_reading(rd);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (lux_sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic alc_pkg::reading_t random_reading();
        alc_pkg::reading_t rd;
        rd.visible_count = 16'($urandom);
        rd.ir_count      = 16'($urandom);
        case ($urandom_range(0, 7))
            0:       rd.visible_count = '0;
            1:       rd.visible_count = 16'($urandom_range(1, 15));
            2:       rd.ir_count = rd.visible_count;
            3:       rd.ir_count = rd.visible_count - 16'($urandom_range(0, 7));
            default: ;
        endcase
        return rd;
    endfunction

    initial
    begin
        logic [31:0] directed [13];
        logic [2:0]  tcode;
        logic [1:0]  gcode;
        bit          no_idle;

        // {visible, infrared}
        directed = '{
            32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF,
            32'h0001_FFFF, 32'h0001_0000, 32'h0001_0001, 32'hFFFF_0001,
            32'h8000_FFFF, 32'h1234_5678, 32'hAAAA_5555, 32'h5555_AAAA,
            32'h0010_0000
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reg(TIME_ADDR, 32'd0);
        check_reg(GAIN_ADDR, 32'd0);

        // reset settings: shortest time, unity gain, saturation reachable
        foreach (directed[i])
            send_reading(alc_pkg::reading_t'(directed[i]), $urandom_range(0, 16));
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       begin tcode = 3'd5; gcode = 2'd3; end
                1:       begin tcode = 3'd7; gcode = 2'd1; end
                2:       begin tcode = 3'd6; gcode = 2'd2; end
                3:       begin tcode = 3'd0; gcode = 2'd0; end
                default: begin tcode = 3'($urandom_range(0, 7)); gcode = 2'($urandom); end
            endcase
            set_config(tcode, gcode);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_reading(random_reading(), no_idle ? 0 : $urandom_range(0, 16));
            drain();
        end

        repeat (alc_pkg::LATENCY + 8) @(posedge clk);
        if (lux_sb.errors == 0 && lux_sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
